// ----- src/ltcc_pkg.sv -----
// ----------------------------------------------------------------------------
// ltcc_pkg
// Shared constants and result word type of the LRU tag cache controller.
// ----------------------------------------------------------------------------
package ltcc_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned TARGET_W = 4;
  localparam int unsigned RESULT_W = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL       = 2'd1;
  localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;

  // Tag value that marks an empty slot
  localparam logic [TAG_W-1:0] EMPTY_TAG = '1;

  // One result word
  typedef struct packed {
    logic                hit;
    logic [RESULT_W-1:0] result_slot;
    logic                evicted;
    logic [TAG_W-1:0]    evicted_index;
  } result_t;

endpackage

// ----- src/ltcc_slot_cell.sv -----
// ----------------------------------------------------------------------------
// ltcc_slot_cell
// One cache slot: holds a tag and a stamp, folds its entry into the search
// word passing down the chain, and applies the write-back aimed at it.
// ----------------------------------------------------------------------------
module ltcc_slot_cell #(
  parameter int unsigned CACHE_SLOTS = 16,
  parameter int unsigned STAMP_BITS  = 32,
  parameter int unsigned SLOT_ID     = 0,
  localparam int unsigned SLOT_W     = $clog2(CACHE_SLOTS)
) (
  input  logic clk_i,
  input  logic rst_ni,
  // search word from the previous cell and towards the next
  input  logic [SLOT_W+STAMP_BITS+ltcc_pkg::TAG_W*2+ltcc_pkg::OP_W+3:0] rec_i,
  output logic [SLOT_W+STAMP_BITS+ltcc_pkg::TAG_W*2+ltcc_pkg::OP_W+3:0] rec_o,
  // write-back broadcast
  input  logic [SLOT_W+STAMP_BITS+ltcc_pkg::TAG_W+2:0]                  wb_i
);

  typedef struct packed {
    logic                       valid;
    logic [ltcc_pkg::OP_W-1:0]  op;
    logic [ltcc_pkg::TAG_W-1:0] key;
    logic                       hit;
    logic                       found_empty;
    logic                       has_pick;
    logic [SLOT_W-1:0]          pick;
    logic [STAMP_BITS-1:0]      best_stamp;
    logic [ltcc_pkg::TAG_W-1:0] best_tag;
  } rec_t;

  typedef struct packed {
    logic                       valid;
    logic                       wr_tag;
    logic                       wr_stamp;
    logic [SLOT_W-1:0]          slot;
    logic [ltcc_pkg::TAG_W-1:0] tag;
    logic [STAMP_BITS-1:0]      stamp;
  } wb_t;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT_ID);

  rec_t                       rec_in;
  rec_t                       rec_d;
  rec_t                       rec_q;
  wb_t                        wb;
  logic [ltcc_pkg::TAG_W-1:0] tag_q;
  logic [STAMP_BITS-1:0]      stamp_q;

  assign rec_in = rec_t'(rec_i);
  assign wb     = wb_t'(wb_i);
  assign rec_o  = rec_q;

  // Fold this slot into the search word
  always_comb begin
    rec_d = rec_in;
    if (rec_in.op == ltcc_pkg::OP_LOOKUP) begin
      if (!rec_in.hit && rec_in.key != ltcc_pkg::EMPTY_TAG && tag_q == rec_in.key) begin
        rec_d.hit  = 1'b1;
        rec_d.pick = MY_SLOT;
      end
    end else if (rec_in.op == ltcc_pkg::OP_FILL) begin
      if (!rec_in.found_empty) begin
        priority if (tag_q == ltcc_pkg::EMPTY_TAG) begin
          rec_d.found_empty = 1'b1;
          rec_d.has_pick    = 1'b1;
          rec_d.pick        = MY_SLOT;
        end else if (!rec_in.has_pick || stamp_q < rec_in.best_stamp) begin
          rec_d.has_pick   = 1'b1;
          rec_d.pick       = MY_SLOT;
          rec_d.best_stamp = stamp_q;
          rec_d.best_tag   = tag_q;
        end else begin
          // keep the pick made further up the chain
          rec_d.pick = rec_in.pick;
        end
      end
    end
  end

  // Advance the search word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  // Apply the write-back aimed at this slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= ltcc_pkg::EMPTY_TAG;
      stamp_q <= '0;
    end else if (wb.valid && wb.slot == MY_SLOT) begin
      if (wb.wr_tag) begin
        tag_q <= wb.tag;
      end
      if (wb.wr_stamp) begin
        stamp_q <= wb.stamp;
      end
    end
  end

endmodule

// ----- src/lru_tag_cache_controller_core.sv -----
// The search word is registered in each slot cell down the chain; the result
// word is then registered at the output. Only one word is in flight: a new
// word is accepted only after the previous one has left the chain and written back.
// A finished result waits in an output register with a one-word skid behind it.
// Reset: every slot empty (tags all ones), stamps and access counter zero.
// ----------------------------------------------------------------------------
// lru_tag_cache_controller_core
// Fully associative tag store with timestamp LRU replacement built as a
// chain of slot cells; lookup, fill and invalidate operations.
// ----------------------------------------------------------------------------
module lru_tag_cache_controller_core #(
  parameter int unsigned CACHE_SLOTS = 16,
  parameter int unsigned STAMP_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ltcc_pkg::OP_W-1:0]     op_i,
  input  logic [ltcc_pkg::TAG_W-1:0]    cluster_index_i,
  input  logic [ltcc_pkg::TARGET_W-1:0] target_slot_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [ltcc_pkg::RESULT_W-1:0] result_slot_o,
  output logic                          evicted_o,
  output logic [ltcc_pkg::TAG_W-1:0]    evicted_index_o
);

  localparam int unsigned SLOT_W = $clog2(CACHE_SLOTS);
  localparam int unsigned WIDE_W = SLOT_W + ltcc_pkg::TARGET_W;

  typedef struct packed {
    logic                       valid;
    logic [ltcc_pkg::OP_W-1:0]  op;
    logic [ltcc_pkg::TAG_W-1:0] key;
    logic                       hit;
    logic                       found_empty;
    logic                       has_pick;
    logic [SLOT_W-1:0]          pick;
    logic [STAMP_BITS-1:0]      best_stamp;
    logic [ltcc_pkg::TAG_W-1:0] best_tag;
  } rec_t;

  typedef struct packed {
    logic                       valid;
    logic                       wr_tag;
    logic                       wr_stamp;
    logic [SLOT_W-1:0]          slot;
    logic [ltcc_pkg::TAG_W-1:0] tag;
    logic [STAMP_BITS-1:0]      stamp;
  } wb_t;

  rec_t                          rec [CACHE_SLOTS+1];
  rec_t                          fin;
  wb_t                           wb;
  ltcc_pkg::result_t             res;
  ltcc_pkg::result_t             out_q;
  ltcc_pkg::result_t             skid_q;
  logic                          out_valid_q;
  logic                          skid_valid_q;
  logic                          busy_q;
  logic [ltcc_pkg::TARGET_W-1:0] target_q;
  logic [STAMP_BITS-1:0]         count_q;
  logic [STAMP_BITS-1:0]         stamp_next;
  logic                          accept;
  logic                          done;
  logic                          out_take;
  logic                          stamp_upd;
  logic [WIDE_W-1:0]             target_wide;
  logic [WIDE_W-1:0]             pick_wide;
  logic                          target_ok;

  assign in_ready_o = !busy_q && !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  // Seed the search word at the head of the chain
  always_comb begin
    rec[0]       = '0;
    rec[0].valid = accept;
    rec[0].op    = op_i;
    rec[0].key   = cluster_index_i;
  end

  // Slot chain
  for (genvar g = 0; g < CACHE_SLOTS; g++) begin : g_cell
    ltcc_slot_cell #(
      .CACHE_SLOTS (CACHE_SLOTS),
      .STAMP_BITS  (STAMP_BITS),
      .SLOT_ID     (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .rec_i  (rec[g]),
      .rec_o  (rec[g+1]),
      .wb_i   (wb)
    );
  end

  assign fin  = rec[CACHE_SLOTS];
  assign done = fin.valid;

  // Hold the invalidate target while the word walks the chain
  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_q <= target_slot_i;
    end
  end

  assign target_wide = WIDE_W'(target_q);
  assign target_ok   = (32'(target_q) < CACHE_SLOTS);
  assign pick_wide   = WIDE_W'(fin.pick);
  assign stamp_next  = count_q + STAMP_BITS'(1);
  assign stamp_upd   = (fin.op == ltcc_pkg::OP_LOOKUP && fin.hit) ||
                       (fin.op == ltcc_pkg::OP_FILL);

  // Build the write-back and the result word from the chain output
  always_comb begin
    wb       = '0;
    wb.stamp = stamp_next;
    wb.slot  = fin.pick;
    res      = '0;
    if (fin.op == ltcc_pkg::OP_LOOKUP) begin
      if (fin.hit) begin
        wb.valid        = done;
        wb.wr_stamp     = 1'b1;
        res.hit         = 1'b1;
        res.result_slot = pick_wide[ltcc_pkg::RESULT_W-1:0];
      end
    end else if (fin.op == ltcc_pkg::OP_FILL) begin
      wb.valid        = done;
      wb.wr_tag       = 1'b1;
      wb.wr_stamp     = 1'b1;
      wb.tag          = fin.key;
      res.result_slot = pick_wide[ltcc_pkg::RESULT_W-1:0];
      if (!fin.found_empty) begin
        res.evicted       = 1'b1;
        res.evicted_index = fin.best_tag;
      end
    end else if (fin.op == ltcc_pkg::OP_INVALIDATE) begin
      wb.valid  = done && target_ok;
      wb.wr_tag = 1'b1;
      wb.tag    = ltcc_pkg::EMPTY_TAG;
      wb.slot   = target_wide[SLOT_W-1:0];
    end
  end

  // Track the word in flight and the access counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done && stamp_upd) begin
        count_q <= stamp_next;
      end
    end
  end

  assign out_take = out_valid_q && out_ready_i;

  // Output register with a one-word skid behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (done) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_q.hit;
  assign result_slot_o   = out_q.result_slot;
  assign evicted_o       = out_q.evicted;
  assign evicted_index_o = out_q.evicted_index;

endmodule

// ----- bench/lru_tag_cache_controller_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_tag_cache_controller_core_tb
// Drives lookup, fill and invalidate words into the tag cache controller
// while both sides idle at random. A behavioural copy of the tag, stamp and
// counter state predicts every result word, which is checked field by field.
// ----------------------------------------------------------------------------
module lru_tag_cache_controller_core_tb;

  localparam int unsigned                 SLOTS       = 16;
  localparam logic [ltcc_pkg::OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam int unsigned                 RAND_WORDS  = 625;
  localparam int unsigned                 POOL_SIZE   = 24;
  localparam int unsigned                 STUCK_LIMIT = 3000;
  localparam int unsigned                 DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [ltcc_pkg::OP_W-1:0]     op;
    logic [ltcc_pkg::TAG_W-1:0]    key;
    logic [ltcc_pkg::TARGET_W-1:0] tslot;
    logic                          typed;
    ltcc_pkg::result_t             want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                          in_valid;
  logic                          in_ready;
  logic [ltcc_pkg::OP_W-1:0]     op;
  logic [ltcc_pkg::TAG_W-1:0]    cluster_index;
  logic [ltcc_pkg::TARGET_W-1:0] target_slot;
  logic                          out_valid;
  logic                          out_ready;
  logic                          hit;
  logic [ltcc_pkg::RESULT_W-1:0] result_slot;
  logic                          evicted;
  logic [ltcc_pkg::TAG_W-1:0]    evicted_index;

  // Predictor state
  logic [ltcc_pkg::TAG_W-1:0] tag_mem [SLOTS];
  logic [31:0]                stamp_mem [SLOTS];
  logic [31:0]                access_cnt;

  ltcc_pkg::result_t          expected_words [$];
  stim_row_t                  directed_rows [$];
  logic [ltcc_pkg::TAG_W-1:0] key_pool [POOL_SIZE];
  int unsigned                err_count;
  int unsigned                stuck_cycles;
  int unsigned                hold_cnt;
  bit                         burst_mode;
  ltcc_pkg::result_t          oldest;

  always #6 clk = ~clk;

  lru_tag_cache_controller_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op),
    .cluster_index_i (cluster_index),
    .target_slot_i   (target_slot),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .hit_o           (hit),
    .result_slot_o   (result_slot),
    .evicted_o       (evicted),
    .evicted_index_o (evicted_index)
  );

  // Reset the predicted cache: every slot empty, stamps and counter zero
  function automatic void cache_clear();
    for (int i = 0; i < SLOTS; i++) begin
      tag_mem[i]   = ltcc_pkg::EMPTY_TAG;
      stamp_mem[i] = '0;
    end
    access_cnt = '0;
  endfunction

  // Advance the predicted cache by one word and return its result word
  function automatic ltcc_pkg::result_t cache_predict(
      input logic [ltcc_pkg::OP_W-1:0]     w_op,
      input logic [ltcc_pkg::TAG_W-1:0]    w_key,
      input logic [ltcc_pkg::TARGET_W-1:0] w_slot);
    ltcc_pkg::result_t res;
    int unsigned       pick;
    bit                found_empty;
    res         = '0;
    pick        = 0;
    found_empty = 1'b0;
    unique case (w_op)
      ltcc_pkg::OP_LOOKUP: begin
        if (w_key != ltcc_pkg::EMPTY_TAG) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (tag_mem[i] == w_key) begin
              access_cnt       = access_cnt + 1;
              stamp_mem[i]     = access_cnt;
              res.hit          = 1'b1;
              res.result_slot  = i[ltcc_pkg::RESULT_W-1:0];
              break;
            end
          end
        end
      end
      ltcc_pkg::OP_FILL: begin
        // Lowest empty slot wins, else the smallest stamp, lower slot on a tie
        for (int i = 0; i < SLOTS; i++) begin
          if (tag_mem[i] == ltcc_pkg::EMPTY_TAG) begin
            pick        = i;
            found_empty = 1'b1;
            break;
          end
          if (stamp_mem[i] < stamp_mem[pick]) pick = i;
        end
        if (!found_empty) begin
          res.evicted       = 1'b1;
          res.evicted_index = tag_mem[pick];
        end
        tag_mem[pick]   = w_key;
        access_cnt      = access_cnt + 1;
        stamp_mem[pick] = access_cnt;
        res.result_slot = pick[ltcc_pkg::RESULT_W-1:0];
      end
      ltcc_pkg::OP_INVALIDATE: begin
        if (w_slot < SLOTS) tag_mem[w_slot] = ltcc_pkg::EMPTY_TAG;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic stim_row_t mk_row(input logic [ltcc_pkg::OP_W-1:0] r_op,
                                       input logic [ltcc_pkg::TAG_W-1:0] r_key,
                                       input logic [ltcc_pkg::TARGET_W-1:0] r_slot,
                                       input logic r_typed,
                                       input ltcc_pkg::result_t r_want);
    stim_row_t row;
    row.op    = r_op;
    row.key   = r_key;
    row.tslot = r_slot;
    row.typed = r_typed;
    row.want  = r_want;
    return row;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  // Offer one word after an optional gap, hold it until taken, then predict
  task automatic send_word(input logic [ltcc_pkg::OP_W-1:0] w_op,
                           input logic [ltcc_pkg::TAG_W-1:0] w_key,
                           input logic [ltcc_pkg::TARGET_W-1:0] w_slot,
                           input logic w_typed,
                           input ltcc_pkg::result_t w_want, input int unsigned gap);
    ltcc_pkg::result_t pred;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= w_op;
    cluster_index <= w_key;
    target_slot   <= w_slot;
    do @(posedge clk); while (!in_ready);
    pred = cache_predict(w_op, w_key, w_slot);
    expected_words.push_back(w_typed ? w_want : pred);
  endtask

  // Stall the result side at random, hold ready during burst stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (burst_mode || $urandom_range(0, 99) < 55) begin
      out_ready <= 1'b1;
      hold_cnt  <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b0;
      hold_cnt  <= idle_len();
    end
  end

  // Check each result word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("unexpected result word", 32'({hit, result_slot, evicted}), '0);
      end else begin
        oldest = expected_words.pop_front();
        if (hit !== oldest.hit) flag_mismatch("hit", 32'(hit), 32'(oldest.hit));
        if (result_slot !== oldest.result_slot)
          flag_mismatch("result_slot", 32'(result_slot), 32'(oldest.result_slot));
        if (evicted !== oldest.evicted)
          flag_mismatch("evicted", 32'(evicted), 32'(oldest.evicted));
        if (evicted_index !== oldest.evicted_index)
          flag_mismatch("evicted_index", evicted_index, oldest.evicted_index);
      end
    end
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("lru_tag_cache_controller_core regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned                counted;
    int unsigned                r;
    logic [ltcc_pkg::OP_W-1:0]  r_op;
    logic [ltcc_pkg::TAG_W-1:0] r_key;
    logic [ltcc_pkg::TAG_W-1:0] last_fill;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    op            = ltcc_pkg::OP_LOOKUP;
    cluster_index = '0;
    target_slot   = '0;
    err_count     = 0;
    stuck_cycles  = 0;
    burst_mode    = 1'b0;
    last_fill     = '0;
    counted       = 0;
    cache_clear();

    // Directed rows: empty cache, reserved key, unused op, extremes
    directed_rows.push_back(mk_row(ltcc_pkg::OP_LOOKUP, 32'h0000_0000, 4'd0, 1'b1, '0));
    directed_rows.push_back(mk_row(ltcc_pkg::OP_LOOKUP, ltcc_pkg::EMPTY_TAG, 4'd15, 1'b1,
                                   '0));
    directed_rows.push_back(mk_row(OP_UNUSED, ltcc_pkg::EMPTY_TAG, 4'd15, 1'b1, '0));
    directed_rows.push_back(mk_row(ltcc_pkg::OP_INVALIDATE, 32'h0000_0000, 4'd15, 1'b1,
                                   '0));
    directed_rows.push_back(mk_row(ltcc_pkg::OP_FILL, 32'h0000_0000, 4'd0, 1'b1, '0));
    directed_rows.push_back(mk_row(ltcc_pkg::OP_FILL, 32'hFFFF_FFFE, 4'd0, 1'b1,
                                   {1'b0, 4'd1, 1'b0, 32'h0}));
    // Filling the reserved key leaves the slot empty
    directed_rows.push_back(mk_row(ltcc_pkg::OP_FILL, ltcc_pkg::EMPTY_TAG, 4'd0, 1'b1,
                                   {1'b0, 4'd2, 1'b0, 32'h0}));
    directed_rows.push_back(mk_row(ltcc_pkg::OP_FILL, 32'h0000_1234, 4'd0, 1'b0, '0));
    directed_rows.push_back(mk_row(ltcc_pkg::OP_LOOKUP, 32'h0000_0000, 4'd0, 1'b1,
                                   {1'b1, 4'd0, 1'b0, 32'h0}));
    // Duplicate fill, invalidate the lower copy, then the upper copy hits
    directed_rows.push_back(mk_row(ltcc_pkg::OP_FILL, 32'h0000_0000, 4'd0, 1'b0, '0));
    directed_rows.push_back(mk_row(ltcc_pkg::OP_INVALIDATE, 32'hFFFF_FFFF, 4'd0, 1'b1,
                                   '0));
    directed_rows.push_back(mk_row(ltcc_pkg::OP_LOOKUP, 32'h0000_0000, 4'd0, 1'b0, '0));
    directed_rows.push_back(mk_row(ltcc_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 4'd0, 1'b0, '0));
    // Fill every remaining slot, then force an eviction
    for (int n = 0; n < 13; n++)
      directed_rows.push_back(mk_row(ltcc_pkg::OP_FILL, 32'hA5A5_0000 + n, 4'd0, 1'b0,
                                     '0));
    directed_rows.push_back(mk_row(ltcc_pkg::OP_FILL, 32'hC0DE_5A5A, 4'd0, 1'b0, '0));
    directed_rows.push_back(mk_row(ltcc_pkg::OP_LOOKUP, 32'h0000_1234, 4'd0, 1'b0, '0));

    foreach (key_pool[i]) key_pool[i] = $urandom;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].key, directed_rows[i].tslot,
                directed_rows[i].typed, directed_rows[i].want, idle_len());

    // Random words over a small key pool so hits and evictions keep coming
    while (counted < RAND_WORDS) begin
      burst_mode = (counted >= 150 && counted < 210) || (counted >= 480 && counted < 530);
      if ($urandom_range(0, 39) == 0) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
      r = $urandom_range(0, 99);
      if (r < 45) r_op = ltcc_pkg::OP_LOOKUP;
      else if (r < 80) r_op = ltcc_pkg::OP_FILL;
      else if (r < 95) r_op = ltcc_pkg::OP_INVALIDATE;
      else r_op = OP_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 80) r_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 88) r_key = $urandom;
      else if (r < 94) r_key = ltcc_pkg::EMPTY_TAG;
      else r_key = last_fill;
      if (r_op == ltcc_pkg::OP_FILL) last_fill = r_key;
      send_word(r_op, r_key, 4'($urandom_range(0, 15)), 1'b0, '0, idle_len());
      if (r_op != OP_UNUSED) counted++;
      // Hold the sender once until every outstanding result has come back
      if (counted == 300 && r_op != OP_UNUSED) begin
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
      end
    end

    // Drain the results and let the pipeline settle
    burst_mode = 1'b0;
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_words.size() != 0)
      flag_mismatch("results left over", expected_words.size(), '0);

    if (err_count == 0) begin
      $display("lru_tag_cache_controller_core regression: pass");
    end else begin
      $display("lru_tag_cache_controller_core regression: fail");
    end
    $finish;
  end

endmodule
